// ===== hdl/gsa_pkg.sv =====
// gsa_pkg: request/response structs, command and status codes, controller
// state type and controller/datapath handshake structs for the slot allocator.
// No dependencies.
`default_nettype none

package gsa_pkg;

  // Command codes
  localparam logic [1:0] CMD_CREATE  = 2'd0;
  localparam logic [1:0] CMD_DESTROY = 2'd1;
  localparam logic [1:0] CMD_QUERY   = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_FREE  = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] slot_index;
    logic [7:0]  slot_generation;
  } req_t;

  typedef struct packed {
    logic [15:0] out_index;
    logic [7:0]  out_generation;
    logic        alive;
    logic [1:0]  status;
  } rsp_t;

  typedef enum logic [1:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_CRT
  } state_t;

  // Controller -> datapath
  typedef struct packed {
    logic sweep;          // write one clearing-pass entry
    logic accept;         // capture request, read memories
    logic create_lookup;  // pop head, mark live, read generation of popped slot
    logic finish_simple;  // resolve non-popping request, write back, load result
    logic finish_create;  // load result of a successful create
  } ctl_t;

  // Datapath -> controller
  typedef struct packed {
    logic sweep_last;
    logic create_pop;     // request is create and the queue is not empty
    logic out_busy;       // result register full and not being taken
  } sts_t;

endpackage

`default_nettype wire

// ===== hdl/gsa_ctrl.sv =====
// gsa_ctrl: sequencer for the slot allocator (clearing pass, accept, execute).
// Depends on gsa_pkg.
`default_nettype none

module gsa_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  output gsa_pkg::ctl_t      ctl,
  input  wire gsa_pkg::sts_t sts
);
  import gsa_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_INIT: begin
        ctl.sweep = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready   = 1'b1;
        ctl.accept = in_valid;
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.create_pop) begin
          ctl.create_lookup = 1'b1;
          state_nxt         = S_CRT;
        end else if (!sts.out_busy) begin
          ctl.finish_simple = 1'b1;
          state_nxt         = S_IDLE;
        end
      end
      S_CRT: begin
        if (!sts.out_busy) begin
          ctl.finish_create = 1'b1;
          state_nxt         = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/gsa_dp.sv =====
// gsa_dp: free-list queue, generation and live memories, queue pointers and
// the result register of the slot allocator. Depends on gsa_pkg.
`default_nettype none

module gsa_dp #(
  parameter int MAX_SLOTS = 1024
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire gsa_pkg::ctl_t  ctl,
  output gsa_pkg::sts_t       sts,
  input  wire gsa_pkg::req_t  in_req,
  output logic                out_valid,
  input  wire logic           out_ready,
  output gsa_pkg::rsp_t       out_rsp
);
  import gsa_pkg::*;

  localparam int IW = $clog2(MAX_SLOTS);
  localparam int CW = $clog2(MAX_SLOTS + 1);
  localparam logic [IW-1:0] LAST_POS = IW'(MAX_SLOTS - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(MAX_SLOTS);

  // Memories
  logic [IW-1:0] queue_mem [MAX_SLOTS];
  logic [7:0]    gen_mem   [MAX_SLOTS];
  logic          live_mem  [MAX_SLOTS];

  logic [IW-1:0] queue_q_r;
  logic [7:0]    gen_q_r;
  logic          live_q_r;

  logic [IW-1:0] sweep_r, sweep_nxt;
  logic [IW-1:0] head_r, head_nxt;
  logic [IW-1:0] tail_r, tail_nxt;
  logic [CW-1:0] count_r, count_nxt;
  req_t          req_r;
  logic          out_valid_r, out_valid_nxt;
  rsp_t          out_r, out_nxt;

  logic [IW-1:0] req_addr;
  logic          in_range;
  logic [7:0]    gen_inc;
  logic          free_ok;     // destroy accepted
  logic [IW-1:0] slot_raddr;
  logic          q_we, g_we, l_we;
  logic [IW-1:0] q_waddr, q_wdata, g_waddr, l_waddr;
  logic [7:0]    g_wdata;
  logic          l_wdata;

  assign req_addr = req_r.slot_index[IW-1:0];
  assign in_range = {1'b0, req_r.slot_index} < 17'(MAX_SLOTS);
  assign gen_inc  = gen_q_r + 8'd1;
  assign free_ok  = (req_r.cmd == CMD_DESTROY) && in_range && live_q_r
                    && (count_r < FULL_CNT);

  assign slot_raddr = ctl.create_lookup ? queue_q_r : in_req.slot_index[IW-1:0];

  // Write port selection
  always_comb begin
    q_we    = 1'b0;
    q_waddr = tail_r;
    q_wdata = req_addr;
    g_we    = 1'b0;
    g_waddr = req_addr;
    g_wdata = gen_inc;
    l_we    = 1'b0;
    l_waddr = req_addr;
    l_wdata = 1'b0;
    if (ctl.sweep) begin
      q_we    = 1'b1;
      q_waddr = sweep_r;
      q_wdata = sweep_r;
      g_we    = 1'b1;
      g_waddr = sweep_r;
      g_wdata = 8'd0;
      l_we    = 1'b1;
      l_waddr = sweep_r;
    end else if (ctl.create_lookup) begin
      l_we    = 1'b1;
      l_waddr = queue_q_r;
      l_wdata = 1'b1;
    end else if (ctl.finish_simple && free_ok) begin
      q_we = 1'b1;
      g_we = 1'b1;
      l_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_we) begin
      queue_mem[q_waddr] <= q_wdata;
    end
    if (ctl.accept) begin
      queue_q_r <= queue_mem[head_r];
    end
  end

  always_ff @(posedge clk) begin
    if (g_we) begin
      gen_mem[g_waddr] <= g_wdata;
    end
    if (ctl.accept || ctl.create_lookup) begin
      gen_q_r <= gen_mem[slot_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (l_we) begin
      live_mem[l_waddr] <= l_wdata;
    end
    if (ctl.accept) begin
      live_q_r <= live_mem[slot_raddr];
    end
  end

  // Pointers, count, result register
  always_comb begin
    sweep_nxt     = sweep_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (ctl.sweep) begin
      sweep_nxt = sweep_r + IW'(1);
    end
    if (ctl.create_lookup) begin
      head_nxt  = (head_r == LAST_POS) ? '0 : head_r + IW'(1);
      count_nxt = count_r - CW'(1);
    end
    if (ctl.finish_create) begin
      out_valid_nxt          = 1'b1;
      out_nxt.out_index      = 16'(queue_q_r);
      out_nxt.out_generation = gen_q_r;
      out_nxt.alive          = 1'b0;
      out_nxt.status         = ST_OK;
    end
    if (ctl.finish_simple) begin
      out_valid_nxt          = 1'b1;
      out_nxt.out_index      = req_r.slot_index;
      out_nxt.out_generation = 8'd0;
      out_nxt.alive          = 1'b0;
      out_nxt.status         = ST_OK;
      case (req_r.cmd)
        CMD_CREATE: begin
          // only reached with an empty queue
          out_nxt.out_index = 16'd0;
          out_nxt.status    = ST_FULL;
        end
        CMD_DESTROY: begin
          if (!in_range) begin
            out_nxt.status = ST_RANGE;
          end else if (free_ok) begin
            out_nxt.out_generation = gen_inc;
            tail_nxt  = (tail_r == LAST_POS) ? '0 : tail_r + IW'(1);
            count_nxt = count_r + CW'(1);
          end else begin
            out_nxt.out_generation = gen_q_r;
            out_nxt.status         = ST_FREE;
          end
        end
        CMD_QUERY: begin
          if (!in_range) begin
            out_nxt.status = ST_RANGE;
          end else begin
            out_nxt.out_generation = gen_q_r;
            out_nxt.alive          = (gen_q_r == req_r.slot_generation);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r     <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= FULL_CNT;
      out_valid_r <= 1'b0;
    end else begin
      sweep_r     <= sweep_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (ctl.accept) begin
      req_r <= in_req;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_r;

  assign sts.sweep_last = (sweep_r == LAST_POS);
  assign sts.create_pop = (req_r.cmd == CMD_CREATE) && (count_r != '0);
  assign sts.out_busy   = out_valid_r && !out_ready;

endmodule

`default_nettype wire

// ===== hdl/generational_slot_allocator.sv =====
// out_valid rises once the execute step has registered the result; a create
// that pops first reads the queue, then the generation. Uses gsa_pkg, gsa_ctrl, gsa_dp.
// A new request is taken only after the last one has loaded its result, and the
// final step waits while a held result has not yet been taken.
// Reset: rst_n synchronous; a clearing pass then loads the free list with
// 0..MAX_SLOTS-1, zeroes generations and live marks, in_ready low.
`default_nettype none

module generational_slot_allocator #(
  parameter int MAX_SLOTS = 1024   // 2 .. 65536
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire gsa_pkg::req_t in_req,
  output logic               out_valid,
  input  wire logic          out_ready,
  output gsa_pkg::rsp_t      out_rsp
);
  import gsa_pkg::*;

  ctl_t ctl;
  sts_t sts;

  // Sequencer: clearing pass, request accept, execute/write-back steps.
  // It waits in its final step while the result register is still occupied,
  // so a held result lets one further request in and then stalls the port.
  gsa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .ctl      (ctl),
    .sts      (sts)
  );

  // Datapath: free-list FIFO memory with head/tail/count, generation and
  // live memories (registered reads), request and result registers.
  gsa_dp #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .sts       (sts),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_rsp   (out_rsp)
  );

endmodule

`default_nettype wire
